>>> rtl/mfr_pkg.sv
// ----------------------------------------------------------------------------
// mfr_pkg
// Types and constants shared by the meter frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package mfr_pkg;

   // Configuration port geometry: five 32-bit registers at byte address 4*i.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   // Register indexes.
   localparam logic [REG_IDX_W-1:0] REG_HEADER_BYTE  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_TRAILER_BYTE = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_HEADER_SPAN  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_MAX_FRAME    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd4;

   // Register reset values.
   localparam logic [7:0] RST_HEADER_BYTE  = 8'h68;
   localparam logic [7:0] RST_TRAILER_BYTE = 8'h16;
   localparam logic [3:0] RST_HEADER_SPAN  = 4'd10;
   localparam logic [7:0] RST_MAX_FRAME    = 8'd255;
   localparam logic [7:0] RST_IDLE_TIMEOUT = 8'd50;

   // Frame layout.
   localparam logic [7:0] POS_SECOND_HEAD = 8'd7;
   localparam logic [7:0] POS_LENGTH      = 8'd9;
   localparam logic [8:0] LEN_EXTRA       = 9'd2;

   typedef enum logic [1:0] {
      ACT_CHAR    = 2'd0,
      ACT_TICK    = 2'd1,
      ACT_RELEASE = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_RECV = 2'd1,
      PH_WAIT = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_PARITY   = 3'd0,
      ST_IGNORED  = 3'd1,
      ST_STORED   = 3'd2,
      ST_COMPLETE = 3'd3,
      ST_ABANDON  = 3'd4,
      ST_TICK     = 3'd5,
      ST_TIMEOUT  = 3'd6
   } status_type;

endpackage

`default_nettype wire

>>> rtl/meter_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// meter_frame_receiver_core
// Meter-protocol frame receiver, one event per request transfer.
// ----------------------------------------------------------------------------
// Each request transfer carries one event: a received character (data byte
// plus ninth parity bit), an idle timer tick, or a release after the host has
// processed a finished frame. Every request produces exactly one response
// transfer with a status code; stored bytes come with their buffer position so
// the caller can write its own frame buffer. A header byte seen while idle
// opens a frame; position 7 must repeat the header or the frame is abandoned;
// the frame completes when the byte count reaches the length byte (position 9)
// plus header_span plus 2 and the byte is the trailer, after which characters
// are ignored until a release. Every character reloads the idle timer; a tick
// that brings it to zero returns the receiver to idle. Throughput is one
// request per clock cycle: the state update and status decode are a single
// pass of compares and an 8-bit counter update into the response register.
// The request side stalls only while a response is held by rsp_ready low.
// Configuration is written through the APB port (byte address 4*i) and must
// only change while no transfer is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module meter_frame_receiver_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire logic [1:0]                       req_action,
   input  wire logic [7:0]                       req_data_byte,
   input  wire logic                             req_ninth_bit,
   // response channel
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      mfr_pkg::status_type              rsp_status,
   output      logic [7:0]                       rsp_stored_byte,
   output      logic [7:0]                       rsp_byte_position,
   output      logic [7:0]                       rsp_frame_length,
   // configuration port
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [mfr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [mfr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output      logic [mfr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output      logic                             csr_pready
);

   import mfr_pkg::*;

   // Configuration registers
   logic [7:0] header_byte_ff;
   logic [7:0] trailer_byte_ff;
   logic [3:0] header_span_ff;
   logic [7:0] max_frame_ff;
   logic [7:0] idle_timeout_ff;

   // Receiver state
   phase_type  phase_ff,      phase_in;
   logic [7:0] byte_count_ff, byte_count_in;
   logic [7:0] length_ff,     length_in;
   logic       head_seen_ff,  head_seen_in;
   logic [7:0] countdown_ff,  countdown_in;

   // Response register
   logic       rsp_valid_ff;
   status_type status_ff,     status_in;
   logic [7:0] stored_ff,     stored_in;
   logic [7:0] position_ff,   position_in;
   logic [7:0] flen_ff,       flen_in;

   logic                 req_fire;
   logic                 csr_write;
   logic [REG_IDX_W-1:0] csr_index;
   action_type           action;
   logic [7:0]           pos_cur;
   logic [8:0]           target;

   // ------------------------------------------------------------------------
   // Handshake: take a new request whenever the response register is empty
   // or its content is being transferred out in this cycle.
   // ------------------------------------------------------------------------
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign action    = action_type'(req_action);

   // ------------------------------------------------------------------------
   // Configuration port: zero-wait APB, register i at byte address 4*i.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_index)
         REG_HEADER_BYTE:  csr_prdata = {{(CSR_DATA_W-8){1'b0}}, header_byte_ff};
         REG_TRAILER_BYTE: csr_prdata = {{(CSR_DATA_W-8){1'b0}}, trailer_byte_ff};
         REG_HEADER_SPAN:  csr_prdata = {{(CSR_DATA_W-4){1'b0}}, header_span_ff};
         REG_MAX_FRAME:    csr_prdata = {{(CSR_DATA_W-8){1'b0}}, max_frame_ff};
         REG_IDLE_TIMEOUT: csr_prdata = {{(CSR_DATA_W-8){1'b0}}, idle_timeout_ff};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_byte_ff  <= RST_HEADER_BYTE;
         trailer_byte_ff <= RST_TRAILER_BYTE;
         header_span_ff  <= RST_HEADER_SPAN;
         max_frame_ff    <= RST_MAX_FRAME;
         idle_timeout_ff <= RST_IDLE_TIMEOUT;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_HEADER_BYTE:  header_byte_ff  <= csr_pwdata[7:0];
            REG_TRAILER_BYTE: trailer_byte_ff <= csr_pwdata[7:0];
            REG_HEADER_SPAN:  header_span_ff  <= csr_pwdata[3:0];
            REG_MAX_FRAME:    max_frame_ff    <= csr_pwdata[7:0];
            REG_IDLE_TIMEOUT: idle_timeout_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Next state and response for one request. The working copies are
   // updated in order: frame start clears the receiver first, then the byte
   // is stored and the position-7 / length checks see the updated values.
   // ------------------------------------------------------------------------
   always_comb begin
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      length_in     = length_ff;
      head_seen_in  = head_seen_ff;
      countdown_in  = countdown_ff;
      status_in     = ST_IGNORED;
      stored_in     = '0;
      position_in   = '0;
      flen_in       = '0;
      pos_cur       = '0;
      target        = '0;

      unique case (action)
         ACT_TICK: begin
            countdown_in = countdown_ff - 8'd1;
            if (countdown_in == 8'd0) begin
               // timer expired: drop the partial frame
               phase_in      = PH_IDLE;
               byte_count_in = '0;
               length_in     = '0;
               head_seen_in  = 1'b0;
               status_in     = ST_TIMEOUT;
            end else begin
               status_in = ST_TICK;
            end
         end

         ACT_RELEASE: begin
            phase_in      = PH_IDLE;
            byte_count_in = '0;
            length_in     = '0;
            head_seen_in  = 1'b0;
         end

         ACT_CHAR: begin
            // every character, good parity or not, reloads the idle timer
            countdown_in = idle_timeout_ff;
            if ((^req_data_byte) != req_ninth_bit) begin
               status_in = ST_PARITY;
            end else begin
               if (phase_ff == PH_IDLE && req_data_byte == header_byte_ff) begin
                  phase_in      = PH_RECV;
                  byte_count_in = '0;
                  length_in     = '0;
                  head_seen_in  = 1'b0;
               end
               if (phase_in == PH_RECV && byte_count_in < max_frame_ff) begin
                  pos_cur = byte_count_in;
                  if (pos_cur == POS_SECOND_HEAD) begin
                     head_seen_in = (req_data_byte == header_byte_ff);
                  end
                  if (pos_cur == POS_LENGTH) begin
                     length_in = req_data_byte;
                  end
                  byte_count_in = pos_cur + 8'd1;
                  status_in     = ST_STORED;
                  stored_in     = req_data_byte;
                  position_in   = pos_cur;
                  target        = {1'b0, length_in} + {5'd0, header_span_ff} + LEN_EXTRA;
                  if (byte_count_in > {4'd0, header_span_ff}) begin
                     if (!head_seen_in) begin
                        // second header missing: abandon the frame
                        phase_in      = PH_IDLE;
                        byte_count_in = '0;
                        length_in     = '0;
                        head_seen_in  = 1'b0;
                        status_in     = ST_ABANDON;
                        stored_in     = '0;
                        position_in   = '0;
                     end else if ({1'b0, byte_count_in} >= target &&
                                  req_data_byte == trailer_byte_ff) begin
                        // frame complete: hold until released
                        phase_in  = PH_WAIT;
                        status_in = ST_COMPLETE;
                        flen_in   = byte_count_in;
                     end
                  end
               end
            end
         end

         default: ;
      endcase
   end

   // ------------------------------------------------------------------------
   // State and response registers. Advance state only on an accepted
   // request; hold the response until it is transferred out.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         byte_count_ff <= '0;
         length_ff     <= '0;
         head_seen_ff  <= 1'b0;
         countdown_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff      <= phase_in;
            byte_count_ff <= byte_count_in;
            length_ff     <= length_in;
            head_seen_ff  <= head_seen_in;
            countdown_ff  <= countdown_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff   <= status_in;
         stored_ff   <= stored_in;
         position_ff <= position_in;
         flen_ff     <= flen_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_stored_byte   = stored_ff;
   assign rsp_byte_position = position_ff;
   assign rsp_frame_length  = flen_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // A held response must stall the request side.
   a_stall_on_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while response held");

   // An idle receiver carries no partial frame.
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (byte_count_ff == 8'd0 && length_ff == 8'd0 &&
                                 !head_seen_ff))
      else $error("idle receiver holds frame state");

   // A completed frame parks the receiver until release.
   a_complete_waits: assert property (@(posedge clock) disable iff (reset)
      (req_fire && status_in == ST_COMPLETE) |=> (phase_ff == PH_WAIT))
      else $error("completed frame did not enter wait phase");

endmodule

`default_nettype wire

>>> verif/meter_frame_receiver_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_frame_receiver_core_tb
// Self-checking bench for the meter frame receiver core.
// ----------------------------------------------------------------------------
// A queue of UART characters, timer ticks and releases is filled per phase and
// fed to the request channel in random bursts. Every accepted transfer is run
// through a cycle-free model of the receiver, and each response transfer is
// compared field by field with the oldest predicted result. Between phases
// the APB port rewrites the configuration while the core is idle, covering
// both extremes of each register but header_span, which keeps its reset value.
// ----------------------------------------------------------------------------

module meter_frame_receiver_core_tb;

   import mfr_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int LONG_STALL_AT   = 300;   // response count that triggers the long hold-off
   localparam int LONG_STALL_LEN  = 200;
   localparam int FRAME_OVERHEAD  = 12;    // length byte + header_span + 2

   typedef struct packed {
      action_type act;
      logic [7:0] data;
      logic       ninth;
   } rx_char_t;

   typedef struct packed {
      status_type status;
      logic [7:0] byte_val;
      logic [7:0] pos;
      logic [7:0] len;
   } rx_result_t;

   // DUT signals
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_action = ACT_NONE;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_ninth_bit = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   status_type rsp_status;
   logic [7:0] rsp_stored_byte;
   logic [7:0] rsp_byte_position;
   logic [7:0] rsp_frame_length;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Configuration mirror
   logic [7:0] cfg_header  = RST_HEADER_BYTE;
   logic [7:0] cfg_trailer = RST_TRAILER_BYTE;
   logic [3:0] cfg_span    = RST_HEADER_SPAN;
   logic [7:0] cfg_max     = RST_MAX_FRAME;
   logic [7:0] cfg_timeout = RST_IDLE_TIMEOUT;

   // Receiver state mirror
   phase_type  rx_phase     = PH_IDLE;
   logic [7:0] rx_count     = 8'd0;
   logic [7:0] rx_length    = 8'd0;
   logic       rx_head2_ok  = 1'b0;
   logic [7:0] rx_countdown = 8'd0;

   rx_char_t   char_backlog[$];     // characters waiting to be offered
   rx_result_t awaited_results[$];  // predicted responses, oldest first

   int failures      = 0;
   int cycle_count   = 0;
   int results_seen  = 0;
   int burst_left    = 1;
   int gap_left      = 0;
   int hold_left     = 0;
   int window_left   = 0;
   int ready_mode    = 0;
   int pattern_step  = 0;
   bit long_stall_done = 1'b0;

   meter_frame_receiver_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_data_byte     (req_data_byte),
      .req_ninth_bit     (req_ninth_bit),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_stored_byte   (rsp_stored_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_frame_length  (rsp_frame_length),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Receiver model
   // ------------------------------------------------------------------------
   // Drop back to idle with the frame bookkeeping cleared; the timer is kept.
   function automatic void rx_clear();
      rx_phase    = PH_IDLE;
      rx_count    = 8'd0;
      rx_length   = 8'd0;
      rx_head2_ok = 1'b0;
   endfunction

   // Advance the model by one accepted transfer and return its response.
   function automatic rx_result_t receiver_step(action_type act, logic [7:0] data,
                                                logic ninth);
      rx_result_t r;
      logic [7:0] pos;
      logic [8:0] target;
      r.status   = ST_IGNORED;
      r.byte_val = 8'h00;
      r.pos      = 8'h00;
      r.len      = 8'h00;
      case (act)
         ACT_TICK: begin
            // modulo-256 countdown: a tick from zero wraps without a reset
            rx_countdown = rx_countdown - 8'd1;
            if (rx_countdown == 8'd0) begin
               rx_clear();
               r.status = ST_TIMEOUT;
            end else begin
               r.status = ST_TICK;
            end
         end
         ACT_RELEASE: rx_clear();
         ACT_CHAR: begin
            // every character reloads the timer, even one that fails parity
            rx_countdown = cfg_timeout;
            if ((^data) != ninth) begin
               r.status = ST_PARITY;
            end else begin
               if (rx_phase == PH_IDLE && data == cfg_header) begin
                  rx_clear();
                  rx_phase = PH_RECV;
               end
               if (rx_phase == PH_RECV && rx_count < cfg_max) begin
                  pos = rx_count;
                  if (pos == POS_SECOND_HEAD) rx_head2_ok = (data == cfg_header);
                  if (pos == POS_LENGTH) rx_length = data;
                  rx_count   = pos + 8'd1;
                  r.status   = ST_STORED;
                  r.byte_val = data;
                  r.pos      = pos;
                  if (rx_count > cfg_span) begin
                     target = {1'b0, rx_length} + cfg_span + LEN_EXTRA;
                     if (!rx_head2_ok) begin
                        rx_clear();
                        r.status   = ST_ABANDON;
                        r.byte_val = 8'h00;
                        r.pos      = 8'h00;
                     end else if ({1'b0, rx_count} >= target && data == cfg_trailer) begin
                        rx_phase = PH_WAIT;
                        r.status = ST_COMPLETE;
                        r.len    = rx_count;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic void add_item(action_type act, logic [7:0] data, logic ninth);
      rx_char_t c;
      c.act   = act;
      c.data  = data;
      c.ninth = ninth;
      char_backlog.push_back(c);
   endfunction

   // Queue a character with correct or deliberately broken parity.
   function automatic void add_char(logic [7:0] data, bit good);
      add_item(ACT_CHAR, data, (^data) ^ !good);
   endfunction

   // Queue a whole frame built for the current settings. With noise on, a
   // stray tick or a parity-failing character may land between its bytes.
   function automatic void add_frame(int len_byte, bit break_head2, bit noisy);
      int total;
      logic [7:0] b;
      total = len_byte + FRAME_OVERHEAD;
      for (int p = 0; p < total; p++) begin
         if (p == 0) b = cfg_header;
         else if (p == int'(POS_SECOND_HEAD))
            b = break_head2 ? cfg_header ^ 8'($urandom_range(1, 255)) : cfg_header;
         else if (p == int'(POS_LENGTH)) b = 8'(len_byte);
         else if (p == total - 1) b = cfg_trailer;
         else b = 8'($urandom);
         add_char(b, 1'b1);
         if (noisy && $urandom_range(0, 99) < 3) add_char(8'($urandom), 1'b0);
         if (noisy && $urandom_range(0, 99) < 3) add_item(ACT_TICK, 8'($urandom), 1'($urandom));
      end
   endfunction

   // Mostly well-formed frames with random content, the rest noise.
   function automatic void add_traffic(int n);
      int start;
      int room;
      int len_byte;
      int pick;
      start = char_backlog.size();
      while (char_backlog.size() - start < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            room = int'(cfg_max) - FRAME_OVERHEAD;
            if ($urandom_range(0, 9) == 0)
               len_byte = $urandom_range(0, room < 40 ? room : 40);
            else
               len_byte = $urandom_range(0, room < 8 ? room : 8);
            add_frame(len_byte, $urandom_range(0, 9) == 0, 1'b1);
            if ($urandom_range(0, 3) == 0) add_char(8'($urandom), $urandom_range(0, 4) != 0);
            if ($urandom_range(0, 9) != 0) add_item(ACT_RELEASE, 8'($urandom), 1'($urandom));
         end else if (pick < 75) begin
            repeat ($urandom_range(1, 8)) add_item(ACT_TICK, 8'($urandom), 1'($urandom));
         end else if (pick < 85) begin
            add_char(8'($urandom), $urandom_range(0, 3) != 0);
         end else if (pick < 93) begin
            add_item(ACT_RELEASE, 8'($urandom), 1'($urandom));
         end else begin
            add_item(ACT_NONE, 8'($urandom), 1'($urandom));
         end
      end
   endfunction

   // APB write: setup cycle, then access cycle; pready is always high.
   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [7:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_HEADER_BYTE:  cfg_header  = value;
         REG_TRAILER_BYTE: cfg_trailer = value;
         REG_HEADER_SPAN:  cfg_span    = value[3:0];
         REG_MAX_FRAME:    cfg_max     = value;
         REG_IDLE_TIMEOUT: cfg_timeout = value;
         default: ;
      endcase
   endtask

   task automatic write_all(logic [7:0] header, logic [7:0] trailer, logic [7:0] max_bytes,
                            logic [7:0] timeout);
      csr_write(REG_HEADER_BYTE, header);
      csr_write(REG_TRAILER_BYTE, trailer);
      csr_write(REG_HEADER_SPAN, 8'(RST_HEADER_SPAN));
      csr_write(REG_MAX_FRAME, max_bytes);
      csr_write(REG_IDLE_TIMEOUT, timeout);
   endtask

   // Hold the thread until every queued character went out and every
   // predicted response came back.
   task automatic wait_drained();
      do @(negedge clock);
      while (char_backlog.size() != 0 || req_valid || awaited_results.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Request driver: bursts of random length separated by random gaps
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      rx_char_t c;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // predict at the edge the transfer is taken, from the held payload
         if (req_valid && req_ready)
            awaited_results.push_back(receiver_step(action_type'(req_action),
                                                    req_data_byte, req_ninth_bit));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (char_backlog.size() > 0) begin
               c = char_backlog.pop_front();
               req_valid     <= 1'b1;
               req_action    <= c.act;
               req_data_byte <= c.data;
               req_ninth_bit <= c.ninth;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor and ready pattern
   // ------------------------------------------------------------------------
   task automatic check_result(rx_result_t exp);
      if (rsp_status !== exp.status) begin
         $error("status: expected %0d, got %0d", exp.status, rsp_status);
         failures++;
      end
      if (rsp_stored_byte !== exp.byte_val) begin
         $error("stored_byte: expected 0x%02h, got 0x%02h", exp.byte_val, rsp_stored_byte);
         failures++;
      end
      if (rsp_byte_position !== exp.pos) begin
         $error("byte_position: expected %0d, got %0d", exp.pos, rsp_byte_position);
         failures++;
      end
      if (rsp_frame_length !== exp.len) begin
         $error("frame_length: expected %0d, got %0d", exp.len, rsp_frame_length);
         failures++;
      end
   endtask

   always @(posedge clock) begin : watch_results
      logic ready_next;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("status: expected none, got %0d", rsp_status);
               failures++;
            end else begin
               check_result(awaited_results.pop_front());
            end
            results_seen++;
         end
         // one long hold-off fills the core and back-pressures the sender
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (!long_stall_done && results_seen >= LONG_STALL_AT) begin
            long_stall_done = 1'b1;
            hold_left  = LONG_STALL_LEN - 1;
            ready_next = 1'b0;
         end else begin
            if (window_left <= 0) begin
               ready_mode  = $urandom_range(0, 3);
               window_left = $urandom_range(20, 80);
            end
            window_left--;
            pattern_step++;
            case (ready_mode)
               0: ready_next = 1'b1;
               1: ready_next = ($urandom_range(0, 3) != 0);
               2: ready_next = 1'($urandom_range(0, 1));
               default: ready_next = ((pattern_step % 7) < 3);
            endcase
         end
         rsp_ready <= ready_next;
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("meter_frame_receiver_core_tb NOT OK");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: timer wrap from zero, unused action, parity drop,
      // release while idle, idle garbage, a minimal frame, then a character
      // while waiting for release.
      add_item(ACT_TICK, 8'h00, 1'b0);
      add_item(ACT_NONE, 8'hA5, 1'b1);
      add_char(8'h68, 1'b0);
      add_item(ACT_RELEASE, 8'h5A, 1'b0);
      add_char(8'h00, 1'b1);
      add_char(8'hFF, 1'b1);
      add_frame(0, 1'b0, 1'b0);
      add_char(8'h68, 1'b1);
      add_item(ACT_RELEASE, 8'hFF, 1'b1);
      wait_drained();

      // Low extremes: a frame longer than the buffer fills it, the next
      // character is ignored, and a single tick expires the timer.
      write_all(8'h00, 8'hFF, 8'd12, 8'd1);
      add_frame(1, 1'b0, 1'b0);
      add_char(8'h3C, 1'b1);
      add_item(ACT_TICK, 8'h00, 1'b0);
      add_traffic(25);
      wait_drained();

      // High extremes: one longest frame, then random traffic. The long
      // receiver hold-off falls in this phase.
      write_all(8'hFF, 8'h00, 8'd255, 8'd255);
      add_frame(int'(RST_MAX_FRAME) - FRAME_OVERHEAD, 1'b0, 1'b0);
      add_item(ACT_RELEASE, 8'h00, 1'b0);
      add_traffic(30);
      wait_drained();

      // Standard bytes with a short timer so timeouts occur mid-frame.
      write_all(RST_HEADER_BYTE, RST_TRAILER_BYTE, 8'd40, 8'd4);
      add_traffic(35);
      wait_drained();
      add_traffic(25);
      wait_drained();

      // Random settings.
      write_all(8'($urandom), 8'($urandom), 8'($urandom_range(12, 255)),
                8'($urandom_range(1, 255)));
      add_traffic(30);
      wait_drained();

      repeat (4) @(posedge clock);
      if (failures == 0)
         $display("meter_frame_receiver_core_tb OK");
      else
         $display("meter_frame_receiver_core_tb NOT OK");
      $finish;
   end

endmodule
